[rtl/hrot_pkg.sv]
package hrot_pkg;

	// fixed point formats
	localparam int COEF_FRAC_BITS = 13;
	localparam int COEF_W         = 16;
	localparam int ANGLE_STEPS    = 360;
	localparam int ANGLE_W        = 9;
	localparam int CHAN_W         = 8;

	// pi in Q30
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// quarter-wave sine table, unsigned Q16, one entry per degree
	localparam int SINE_W     = 17;
	localparam int SINE_DEPTH = 91;

	// rounded divide by 65536000 after the fraction scale:
	// (mag + 500 * 2^(16-frac)) / (1000 * 2^(16-frac)), done as a shift then a divide by 125
	localparam int COEF_HALF      = 500 << (16 - COEF_FRAC_BITS);
	localparam int COEF_PRE_SHIFT = 16 - COEF_FRAC_BITS + 3;

	// divide by 125 as a multiply by ceil(2^30 / 125), exact for 23-bit operands
	localparam logic [23:0] RECIP_M     = 24'd8589935;
	localparam int          RECIP_SHIFT = 30;

	// matrix at angle zero
	localparam int COEF_ONE_I  = 1 << COEF_FRAC_BITS;
	localparam int COEF_LEAK_I = (COEF_ONE_I + 500) / 1000;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [15:0]       packed_565;
	} pixel_out_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [8:0] coef_mat_t;

	// integer taylor series up to x^13 in Q30, rounded half up to Q16
	function automatic logic [SINE_DEPTH*SINE_W-1:0] sine_table_init();
		logic [SINE_DEPTH*SINE_W-1:0] t;
		longint unsigned              x;
		longint unsigned              term;
		longint                       sum;
		t = '0;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			x    = (64'(k) * 64'(PI_Q30)) / 64'd180;
			term = x;
			sum  = signed'(x);
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n[0]) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			t[k*SINE_W +: SINE_W] = SINE_W'((sum + 64'sd8192) >>> 14);
		end
		return t;
	endfunction

	localparam logic [SINE_DEPTH*SINE_W-1:0] SINE_LUT = sine_table_init();

	function automatic coef_mat_t coef_reset_mat();
		coef_mat_t m;
		m    = '0;
		m[0] = coef_t'(COEF_ONE_I);
		m[4] = coef_t'(COEF_ONE_I);
		m[6] = coef_t'(-COEF_LEAK_I);
		m[7] = coef_t'(-COEF_LEAK_I);
		m[8] = coef_t'(COEF_ONE_I);
		return m;
	endfunction

	// base term of each coefficient, thousandths
	function automatic logic [9:0] mat_a(input logic [3:0] idx);
		logic [9:0] v;
		case (idx)
			4'd0, 4'd3, 4'd6: v = 10'd299;
			4'd1, 4'd4, 4'd7: v = 10'd587;
			4'd2, 4'd5, 4'd8: v = 10'd114;
			default:          v = 10'd0;
		endcase
		return v;
	endfunction

	// cosine factor, thousandths
	function automatic logic signed [11:0] mat_b(input logic [3:0] idx);
		logic signed [11:0] v;
		case (idx)
			4'd0:    v = 12'sd701;
			4'd1:    v = -12'sd587;
			4'd2:    v = -12'sd114;
			4'd3:    v = -12'sd299;
			4'd4:    v = 12'sd413;
			4'd5:    v = -12'sd114;
			4'd6:    v = -12'sd300;
			4'd7:    v = -12'sd588;
			4'd8:    v = 12'sd886;
			default: v = 12'sd0;
		endcase
		return v;
	endfunction

	// sine factor, thousandths
	function automatic logic signed [11:0] mat_c(input logic [3:0] idx);
		logic signed [11:0] v;
		case (idx)
			4'd0:    v = 12'sd168;
			4'd1:    v = 12'sd330;
			4'd2:    v = -12'sd497;
			4'd3:    v = -12'sd328;
			4'd4:    v = 12'sd35;
			4'd5:    v = 12'sd292;
			4'd6:    v = 12'sd1250;
			4'd7:    v = -12'sd1050;
			4'd8:    v = -12'sd203;
			default: v = 12'sd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/hue_rotate_rgb_pixel.sv]
// done is high for one cycle per accepted request, together with its stage 4 result
// throughput: one pixel per cycle through the four-stage multiply-add pipeline while busy is low
// an angle write keeps busy high through the sine lookup, then the multiply, sum, round and
// divide steps for each of the nine coefficients; no pixel is taken meanwhile
// reset loads angle zero and its matrix and empties the pipeline; results cannot be stalled
module hue_rotate_rgb_pixel import hrot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pixel_in_t          pixel,
	output logic               done,
	output pixel_out_t         result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ANGLE_W-1:0] cfg_data
);

	localparam int PROD_W = COEF_W + CHAN_W + 1;
	localparam int ACC_W  = PROD_W + 2;

	coef_mat_t                coef;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic                     v_s4;
	logic [CHAN_W-1:0]        ch_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [9];
	logic signed [ACC_W-1:0]  acc_s3 [3];
	logic [CHAN_W-1:0]        sat [3];
	pixel_out_t               res_s4;

	logic [ACC_W-COEF_FRAC_BITS-1:0] int_part [3];

	// matrix builder
	hrot_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.coef      (coef)
	);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: capture pixel
	always_ff @(posedge clk) begin
		ch_s1[0] <= pixel.red_in;
		ch_s1[1] <= pixel.green_in;
		ch_s1[2] <= pixel.blue_in;
	end

	// stage 2: nine coefficient products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			prod_s2[i] <= PROD_W'(coef[i] * $signed({1'b0, ch_s1[i % 3]}));
		end
	end

	// stage 3: row sums
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			acc_s3[r] <= ACC_W'(prod_s2[r*3]) + ACC_W'(prod_s2[r*3+1])
				+ ACC_W'(prod_s2[r*3+2]);
		end
	end

	// truncate toward zero and clamp to a byte
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			int_part[r] = acc_s3[r][ACC_W-1:COEF_FRAC_BITS];
			if (acc_s3[r][ACC_W-1] || acc_s3[r] == '0) begin
				sat[r] = '0;
			end else if (|int_part[r][ACC_W-COEF_FRAC_BITS-1:CHAN_W]) begin
				sat[r] = '1;
			end else begin
				sat[r] = int_part[r][CHAN_W-1:0];
			end
		end
	end

	// stage 4: result register with 565 packing
	always_ff @(posedge clk) begin
		res_s4.red_out    <= sat[0];
		res_s4.green_out  <= sat[1];
		res_s4.blue_out   <= sat[2];
		res_s4.packed_565 <= {sat[0][7:3], sat[1][7:2], sat[2][7:3]};
	end

	assign done   = v_s4;
	assign result = res_s4;

endmodule

[rtl/hrot_coef.sv]
module hrot_coef import hrot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [ANGLE_W-1:0] cfg_data,
	output logic               cfg_ready,
	output logic               busy,
	output coef_mat_t          coef
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b00_0001,
		ST_SETUP = 6'b00_0010,
		ST_CMUL  = 6'b00_0100,
		ST_CNUM  = 6'b00_1000,
		ST_CRND  = 6'b01_0000,
		ST_CDIV  = 6'b10_0000
	} state_t;

	state_t                     state_q;
	logic [ANGLE_W-1:0]         hue_q;
	logic signed [17:0]         w_q;
	logic signed [17:0]         u_q;
	logic [3:0]                 idx_q;
	logic signed [29:0]         pu_q;
	logic signed [29:0]         pw_q;
	logic signed [28:0]         num_q;
	logic [28-COEF_PRE_SHIFT:0] y_q;
	coef_mat_t                  coef_q;

	logic [ANGLE_W-1:0]         hue_red;
	logic [ANGLE_W:0]           cos_sum;
	logic [ANGLE_W-1:0]         cos_ang;
	logic signed [28:0]         num_mag;
	logic [28:0]                rnd_sum;
	logic [46:0]                recip_prod;
	logic [COEF_W-1:0]          coef_mag;

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign coef      = coef_q;

	// signed q16 sine of a whole angle by quadrant symmetry
	function automatic logic signed [17:0] sine_deg(input logic [ANGLE_W-1:0] a);
		logic [6:0]        k;
		logic              neg;
		logic [10:0]       base;
		logic [SINE_W-1:0] mag;
		if (a <= ANGLE_W'(90)) begin
			k   = a[6:0];
			neg = 1'b0;
		end else if (a <= ANGLE_W'(180)) begin
			k   = 7'(ANGLE_W'(180) - a);
			neg = 1'b0;
		end else if (a <= ANGLE_W'(270)) begin
			k   = 7'(a - ANGLE_W'(180));
			neg = 1'b1;
		end else begin
			k   = 7'(ANGLE_W'(ANGLE_STEPS) - a);
			neg = 1'b1;
		end
		base = 11'(k) * 11'(SINE_W);
		mag  = SINE_LUT[base +: SINE_W];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// angle reduction, cosine angle and coefficient rounding
	always_comb begin
		hue_red = (hue_q >= ANGLE_W'(ANGLE_STEPS)) ? hue_q - ANGLE_W'(ANGLE_STEPS) : hue_q;
		cos_sum = {1'b0, hue_red} + (ANGLE_W+1)'(90);
		cos_ang = (cos_sum >= (ANGLE_W+1)'(ANGLE_STEPS)) ?
			ANGLE_W'(cos_sum - (ANGLE_W+1)'(ANGLE_STEPS)) : cos_sum[ANGLE_W-1:0];
		num_mag    = num_q[28] ? -num_q : num_q;
		rnd_sum    = $unsigned(num_mag) + 29'(COEF_HALF);
		recip_prod = 47'(y_q) * 47'(RECIP_M);
		coef_mag   = recip_prod[RECIP_SHIFT+COEF_W-1:RECIP_SHIFT];
	end

	// matrix rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hue_q   <= '0;
			idx_q   <= '0;
			coef_q  <= coef_reset_mat();
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						hue_q   <= cfg_data;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					idx_q   <= '0;
					state_q <= ST_CMUL;
				end
				ST_CMUL: begin
					state_q <= ST_CNUM;
				end
				ST_CNUM: begin
					state_q <= ST_CRND;
				end
				ST_CRND: begin
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					coef_q[idx_q] <= num_q[28] ? -$signed(coef_mag) : $signed(coef_mag);
					if (idx_q == 4'd8) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= ST_CMUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sine lookup and coefficient datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP: begin
				w_q <= sine_deg(hue_red);
				u_q <= sine_deg(cos_ang);
			end
			ST_CMUL: begin
				pu_q <= mat_b(idx_q) * u_q;
				pw_q <= mat_c(idx_q) * w_q;
			end
			ST_CNUM: begin
				num_q <= $signed({3'b0, mat_a(idx_q), 16'b0}) + 29'(pu_q) + 29'(pw_q);
			end
			ST_CRND: begin
				y_q <= rnd_sum[28:COEF_PRE_SHIFT];
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

endmodule
